/* rtl/ihpl_pkg.sv */
// ihpl_pkg: shared types and constants for the hex page loader
// event codes, result record, register indexes, reset values and characters
// no dependencies
package ihpl_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_HEX_TEXT_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_BASE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE     = 2'd2;
    localparam int unsigned CFG_DATA_W = 16;

    // register reset values
    localparam logic        RST_HEX_TEXT_MODE = 1'b1;
    localparam logic [15:0] RST_PAGE_BASE     = 16'h0000;
    localparam logic [7:0]  RST_PAGE_SIZE     = 8'd128;

    // characters the parser looks for
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] REC_TYPE_EOF = 8'h01;

    typedef enum logic [2:0] {
        EV_DATA     = 3'd0,
        EV_OK       = 3'd1,
        EV_CKSUM    = 3'd2,
        EV_END      = 3'd3,
        EV_FULL     = 3'd4,
        EV_BEYOND   = 3'd5,
        EV_FORMAT   = 3'd6,
        EV_OVERFLOW = 3'd7
    } t_event;

    typedef struct packed {
        t_event     kind;
        logic [7:0] data;
        logic [7:0] idx;
    } t_result;

endpackage

/* rtl/intel_hex_page_loader_core.sv */
// intel_hex_page_loader_core: top level of the hex page loader
// configuration registers, parser and result buffer
// depends on ihpl_pkg, ihpl_parser, ihpl_out_buf
//
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+-----------------------------------
// input    | in        | i_in_valid / o_in_ready    | i_char_in, i_restart
// result   | out       | o_out_valid / i_out_ready  | o_event_kind, o_data_byte,
//          |           |                            | o_page_index
// config   | in        | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// the parser state updates at the accepting edge and any result lands in the output register,
// or in the skid stage while the output register holds an untaken result, at that same edge
// a skid stage behind the output register holds one more result while a result
// waits; transactions that give no result keep flowing, and input stalls only
// while both are full
// synchronous active-low reset clears parser state and buffer valids and loads register reset values
module intel_hex_page_loader_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [ihpl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ihpl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input transactions
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_char_in,
    input  logic                              i_restart,
    // result transactions
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [2:0]                        o_event_kind,
    output logic [7:0]                        o_data_byte,
    output logic [7:0]                        o_page_index
);
    import ihpl_pkg::*;

    logic        r_hex_text_mode;
    logic [15:0] r_page_base;
    logic [7:0]  r_page_size;

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    can_push;

    // configuration registers, writes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hex_text_mode <= RST_HEX_TEXT_MODE;
            r_page_base     <= RST_PAGE_BASE;
            r_page_size     <= RST_PAGE_SIZE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HEX_TEXT_MODE: r_hex_text_mode <= i_cfg_data[0];
                REG_PAGE_BASE:     r_page_base     <= i_cfg_data[15:0];
                REG_PAGE_SIZE:     r_page_size     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input is taken whenever the skid stage is free
    assign o_in_ready = can_push;
    assign accept     = i_in_valid & can_push;

    ihpl_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_char_in       (i_char_in),
        .i_restart       (i_restart),
        .i_hex_text_mode (r_hex_text_mode),
        .i_page_base     (r_page_base),
        .i_page_size     (r_page_size),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    ihpl_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (res_valid),
        .i_push_res (res),
        .o_can_push (can_push),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_res      (out_res)
    );

    assign o_event_kind = out_res.kind;
    assign o_data_byte  = out_res.data;
    assign o_page_index = out_res.idx;

endmodule

/* rtl/ihpl_parser.sv */
// ihpl_parser: record parser state and per-transaction update
// one character or raw byte per accepted transaction, at most one result
// depends on ihpl_pkg
module ihpl_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_char_in,
    input  logic              i_restart,
    input  logic              i_hex_text_mode,
    input  logic [15:0]       i_page_base,
    input  logic [7:0]        i_page_size,
    output logic              o_res_valid,
    output ihpl_pkg::t_result o_res
);
    import ihpl_pkg::*;

    typedef enum logic [2:0] {
        PH_COLON   = 3'd0,
        PH_COUNT   = 3'd1,
        PH_ADDR_HI = 3'd2,
        PH_ADDR_LO = 3'd3,
        PH_TYPE    = 3'd4,
        PH_DATA    = 3'd5,
        PH_CKSUM   = 3'd6,
        PH_EOL     = 3'd7
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_hold, n_hold;
    logic [7:0]  r_len, n_len;
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_left, n_left;
    logic [7:0]  r_cks, n_cks;
    logic [7:0]  r_fill, n_fill;
    logic [15:0] r_exp, n_exp;
    logic        r_known, n_known;
    logic        r_halted, n_halted;

    logic        n_res_valid;
    t_result     n_res;

    // hex digit decode, bit 4 flags a valid digit
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = {1'b1, c[3:0] + 4'd9};
        end
        return v;
    endfunction

    always_comb begin
        logic [4:0]  v_dig;
        logic [7:0]  v_b;
        logic        v_have;
        logic [15:0] v_rec_addr;
        logic [16:0] v_limit;
        logic [15:0] v_gap;
        logic [16:0] v_nf;
        logic        v_bad;
        logic        v_full;
        logic        v_text;

        v_dig      = digit_value(i_char_in);
        v_b        = i_char_in;
        v_have     = 1'b0;
        v_rec_addr = {r_addr[15:8], v_b};
        v_limit    = 17'd0;
        v_gap      = 16'd0;
        v_nf       = 17'd0;
        v_bad      = 1'b0;
        v_full     = 1'b0;
        v_text     = i_hex_text_mode;

        n_phase  = r_phase;
        n_hold   = r_hold;
        n_len    = r_len;
        n_addr   = r_addr;
        n_left   = r_left;
        n_cks    = r_cks;
        n_fill   = r_fill;
        n_exp    = r_exp;
        n_known  = r_known;
        n_halted = r_halted;

        n_res_valid = 1'b0;
        n_res       = '{kind: EV_DATA, data: 8'd0, idx: 8'd0};

        // a restart clears tracking before the character is looked at
        if (i_restart) begin
            n_fill   = 8'd0;
            n_exp    = 16'd0;
            n_known  = 1'b0;
            n_halted = 1'b0;
            n_phase  = PH_COLON;
            n_hold   = 5'd0;
        end

        if (!n_halted) begin
            if (!v_text && n_phase == PH_COLON) begin
                n_phase = PH_COUNT;
            end

            if (n_phase == PH_COLON) begin
                if (i_char_in != CHAR_COLON) begin
                    n_halted    = 1'b1;
                    n_res_valid = 1'b1;
                    n_res       = '{kind: EV_FORMAT, data: 8'd0, idx: n_fill};
                end else begin
                    n_hold  = 5'd0;
                    n_phase = PH_COUNT;
                end
            end else if (n_phase == PH_EOL || (!v_text && n_phase == PH_CKSUM)) begin
                // record end: line end in text mode, checksum byte in binary mode
                if (n_phase == PH_EOL && i_char_in != CHAR_NEWLINE) begin
                    n_halted    = 1'b1;
                    n_res_valid = 1'b1;
                    n_res       = '{kind: EV_FORMAT, data: 8'd0, idx: n_fill};
                end else begin
                    if (n_phase == PH_CKSUM) begin
                        n_cks  = n_cks + v_b;
                        n_hold = 5'd0;
                    end
                    v_bad  = (n_cks != 8'd0);
                    v_full = (n_fill == i_page_size);
                    if (v_full) begin
                        n_halted = 1'b1;
                    end else begin
                        n_exp   = n_exp + {8'd0, n_len};
                        n_phase = PH_COLON;
                    end
                    if (n_phase != PH_EOL && r_phase != PH_EOL && v_bad
                            && !(n_phase == PH_COLON && r_phase == PH_EOL)) begin
                        n_res_valid = 1'b0;
                    end
                    // binary checksum error outranks page full
                    if (v_bad && !(i_restart ? 1'b0 : (r_phase == PH_EOL))
                            && !(i_restart && 1'b1)) begin
                        n_res_valid = 1'b1;
                        n_res       = '{kind: EV_CKSUM, data: 8'd0, idx: n_fill};
                    end else if (v_full) begin
                        n_res_valid = 1'b1;
                        n_res       = '{kind: EV_FULL, data: 8'd0, idx: n_fill};
                    end else if (!v_bad) begin
                        n_res_valid = 1'b1;
                        n_res       = '{kind: EV_OK, data: 8'd0, idx: n_fill};
                    end
                end
            end else begin
                // byte assembly
                if (v_text) begin
                    if (!v_dig[4]) begin
                        n_halted    = 1'b1;
                        n_res_valid = 1'b1;
                        n_res       = '{kind: EV_FORMAT, data: 8'd0, idx: n_fill};
                    end else if (!n_hold[4]) begin
                        n_hold = {1'b1, v_dig[3:0]};
                    end else begin
                        v_b    = {n_hold[3:0], v_dig[3:0]};
                        n_hold = 5'd0;
                        v_have = 1'b1;
                    end
                end else begin
                    n_hold = 5'd0;
                    v_have = 1'b1;
                end

                if (v_have) begin
                    v_rec_addr = {n_addr[15:8], v_b};
                    case (n_phase)
                        PH_COUNT: begin
                            n_len   = v_b;
                            n_cks   = v_b;
                            n_phase = PH_ADDR_HI;
                        end
                        PH_ADDR_HI: begin
                            n_addr  = {v_b, 8'd0};
                            n_cks   = n_cks + v_b;
                            n_phase = PH_ADDR_LO;
                        end
                        PH_ADDR_LO: begin
                            n_addr  = v_rec_addr;
                            n_cks   = n_cks + v_b;
                            v_limit = {1'b0, i_page_base} + {9'd0, i_page_size};
                            v_gap   = v_rec_addr - n_exp;
                            v_nf    = {9'd0, n_fill} + {1'b0, v_gap};
                            if ({1'b0, v_rec_addr} >= v_limit) begin
                                n_halted    = 1'b1;
                                n_res_valid = 1'b1;
                                n_res       = '{kind: EV_BEYOND, data: 8'd0, idx: n_fill};
                            end else begin
                                if (!n_known) begin
                                    n_exp   = v_rec_addr;
                                    n_known = 1'b1;
                                end else if (v_rec_addr > n_exp) begin
                                    // gap advances the page index, saturating
                                    n_fill = (v_nf > 17'd255) ? 8'd255 : v_nf[7:0];
                                    n_exp  = v_rec_addr;
                                end
                                n_phase = PH_TYPE;
                            end
                        end
                        PH_TYPE: begin
                            n_cks = n_cks + v_b;
                            if (v_b == REC_TYPE_EOF) begin
                                n_halted    = 1'b1;
                                n_res_valid = 1'b1;
                                n_res       = '{kind: EV_END, data: 8'd0, idx: n_fill};
                            end else begin
                                n_left  = n_len;
                                n_phase = (n_len != 8'd0) ? PH_DATA : PH_CKSUM;
                            end
                        end
                        PH_DATA: begin
                            n_cks = n_cks + v_b;
                            if (n_fill >= i_page_size) begin
                                n_halted    = 1'b1;
                                n_res_valid = 1'b1;
                                n_res       = '{kind: EV_OVERFLOW, data: 8'd0, idx: n_fill};
                            end else begin
                                n_res_valid = 1'b1;
                                n_res       = '{kind: EV_DATA, data: v_b, idx: n_fill};
                                n_fill      = n_fill + 8'd1;
                                n_left      = n_left - 8'd1;
                                if (n_left == 8'd0) begin
                                    n_phase = PH_CKSUM;
                                end
                            end
                        end
                        default: begin
                            // text mode checksum byte, line end follows
                            n_cks   = n_cks + v_b;
                            n_phase = PH_EOL;
                            if (n_cks != 8'd0) begin
                                n_res_valid = 1'b1;
                                n_res       = '{kind: EV_CKSUM, data: 8'd0, idx: n_fill};
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_COLON;
            r_hold   <= 5'd0;
            r_len    <= 8'd0;
            r_addr   <= 16'd0;
            r_left   <= 8'd0;
            r_cks    <= 8'd0;
            r_fill   <= 8'd0;
            r_exp    <= 16'd0;
            r_known  <= 1'b0;
            r_halted <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_hold   <= n_hold;
            r_len    <= n_len;
            r_addr   <= n_addr;
            r_left   <= n_left;
            r_cks    <= n_cks;
            r_fill   <= n_fill;
            r_exp    <= n_exp;
            r_known  <= n_known;
            r_halted <= n_halted;
        end
    end

    assign o_res_valid = i_accept & n_res_valid;
    assign o_res       = n_res;

endmodule

/* rtl/ihpl_out_buf.sv */
// ihpl_out_buf: two-entry result buffer, output register plus skid stage
// lets the parser keep taking transactions while a result waits
// depends on ihpl_pkg
module ihpl_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ihpl_pkg::t_result i_push_res,
    output logic              o_can_push,
    output logic              o_valid,
    input  logic              i_ready,
    output ihpl_pkg::t_result o_res
);
    import ihpl_pkg::*;

    logic    r_main_valid, r_skid_valid;
    t_result r_main, r_skid;
    logic    pop;

    assign pop        = r_main_valid & i_ready;
    assign o_can_push = ~r_skid_valid;
    assign o_valid    = r_main_valid;
    assign o_res      = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main       <= i_push_res;
                r_main_valid <= 1'b1;
            end else begin
                r_skid       <= i_push_res;
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

endmodule
